@@ hw/rtl/read_unknown_base_splitter_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the read splitter
// Shared property forms; they rely on clk and arst_n in the using module.
// ---------------------------------------------------------------------------
`ifndef READ_UNKNOWN_BASE_SPLITTER_UNIT_ASSERT_SVH
`define READ_UNKNOWN_BASE_SPLITTER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define RUBS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define RUBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/rubs_pkg.sv @@
// ---------------------------------------------------------------------------
// Read splitter package
// Shared types and constants for the unknown-base read splitter.
// ---------------------------------------------------------------------------
package rubs_pkg;

	localparam int KMER_W   = 13;
	localparam int TOL_W    = 8;
	localparam int SYM_W    = 8;
	localparam int OFS_W    = 13;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KMER_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_UNK   = 1'b1;

	localparam logic [KMER_W-1:0] KMER_RESET = 13'd31;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 8'd0;

	// unknown base characters
	localparam logic [SYM_W-1:0] CHAR_N   = 8'h4E;
	localparam logic [SYM_W-1:0] CHAR_DOT = 8'h2E;

	// one input word
	typedef struct packed {
		logic             eor;
		logic [SYM_W-1:0] sym;
	} rubs_item_t;

	// one emitted segment
	typedef struct packed {
		logic             fin;
		logic [OFS_W-1:0] seg_end;
		logic [OFS_W-1:0] seg_start;
	} rubs_seg_t;

endpackage

@@ hw/rtl/rubs_in_stage.sv @@
// ---------------------------------------------------------------------------
// Read splitter input stage
// Registers one incoming word; refills in the cycle it is consumed.
// ---------------------------------------------------------------------------
module rubs_in_stage
	import rubs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rubs_item_t in_item,
	input  logic       take,
	output logic       valid_s1,
	output rubs_item_t item_s1
);

	// ready when empty or the held word leaves this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hw/rtl/rubs_seg_tracker.sv @@
// ---------------------------------------------------------------------------
// Read splitter segment tracker
// Holds the per-read offsets and decides breaks one character per cycle while advance is high.
// ---------------------------------------------------------------------------
`include "read_unknown_base_splitter_unit_assert.svh"

module rubs_seg_tracker
	import rubs_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rubs_item_t        item,
	input  logic [KMER_W-1:0] kmer_size,
	input  logic [TOL_W-1:0]  tol_unk,
	output logic              res_valid,
	output rubs_seg_t         res
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = (PW > KMER_W) ? PW : KMER_W;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

	logic [PW-1:0]    position_q, segment_begin_q, stretch_begin_q, stretch_finish_q;
	logic             stretch_seen_q;
	logic [TOL_W-1:0] unknown_count_q;

	logic [PW-1:0]    position_d, segment_begin_d, stretch_begin_d, stretch_finish_d;
	logic             stretch_seen_d;
	logic [TOL_W-1:0] unknown_count_d;

	logic             is_unk, in_range, short_seg, clean_run, over, break_ok;
	logic [PW-1:0]    pos_inc, seg_len, str_len;
	logic [TOL_W:0]   cnt_inc;
	logic [PW-1:0]    res_start, res_end;
	logic [CW-1:0]    start_wide, end_wide;

	// decode and compares
	assign is_unk    = (item.sym == CHAR_N) || (item.sym == CHAR_DOT);
	assign in_range  = position_q < MAX_POS;
	assign pos_inc   = position_q + PW'(1);
	assign seg_len   = position_q - segment_begin_q;
	assign str_len   = position_q - stretch_begin_q;
	assign short_seg = CW'(seg_len) < CW'(kmer_size);
	assign clean_run = CW'(str_len) >= CW'(kmer_size);
	assign cnt_inc   = {1'b0, unknown_count_q} + (TOL_W+1)'(1);
	assign over      = cnt_inc > {1'b0, tol_unk};
	assign break_ok  = stretch_seen_q && (stretch_finish_q > segment_begin_q);

	// next state and result
	always_comb begin
		position_d       = position_q;
		segment_begin_d  = segment_begin_q;
		stretch_begin_d  = stretch_begin_q;
		stretch_finish_d = stretch_finish_q;
		stretch_seen_d   = stretch_seen_q;
		unknown_count_d  = unknown_count_q;
		res_valid        = 1'b0;
		res_start        = segment_begin_q;
		res_end          = position_q;
		if (item.eor) begin
			res_valid        = position_q > segment_begin_q;
			position_d       = '0;
			segment_begin_d  = '0;
			stretch_begin_d  = '0;
			stretch_finish_d = '0;
			stretch_seen_d   = 1'b0;
			unknown_count_d  = '0;
		end else if (in_range) begin
			position_d = pos_inc;
			if (is_unk) begin
				stretch_begin_d = pos_inc;
				if (short_seg) begin
					segment_begin_d = pos_inc;
					unknown_count_d = '0;
				end else if (over) begin
					res_valid       = break_ok;
					res_end         = stretch_finish_q;
					segment_begin_d = pos_inc;
					unknown_count_d = '0;
				end else begin
					unknown_count_d = cnt_inc[TOL_W-1:0];
				end
			end else if (clean_run) begin
				stretch_finish_d = pos_inc;
				stretch_seen_d   = 1'b1;
			end
		end
	end

	// result offsets to port width
	assign start_wide    = CW'(res_start);
	assign end_wide      = CW'(res_end);
	assign res.seg_start = start_wide[OFS_W-1:0];
	assign res.seg_end   = end_wide[OFS_W-1:0];
	assign res.fin       = item.eor;

	// read state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q       <= '0;
			segment_begin_q  <= '0;
			stretch_begin_q  <= '0;
			stretch_finish_q <= '0;
			stretch_seen_q   <= 1'b0;
			unknown_count_q  <= '0;
		end else if (advance) begin
			position_q       <= position_d;
			segment_begin_q  <= segment_begin_d;
			stretch_begin_q  <= stretch_begin_d;
			stretch_finish_q <= stretch_finish_d;
			stretch_seen_q   <= stretch_seen_d;
			unknown_count_q  <= unknown_count_d;
		end
	end

	`RUBS_ASSERT_ALWAYS(a_pos_bound, position_q <= MAX_POS)
	`RUBS_ASSERT_ALWAYS(a_seg_behind, segment_begin_q <= position_q)
	`RUBS_ASSERT_ALWAYS(a_str_behind, stretch_begin_q <= position_q)
	`RUBS_ASSERT_ALWAYS(a_res_nonempty, !(advance && res_valid) || (res_start < res_end))
	`RUBS_ASSERT_NEXT(a_eor_clears, advance && item.eor, position_q == '0 && !stretch_seen_q)

endmodule

@@ hw/rtl/rubs_out_stage.sv @@
// ---------------------------------------------------------------------------
// Read splitter output stage
// Result register toward the downstream stream port.
// ---------------------------------------------------------------------------
module rubs_out_stage
	import rubs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rubs_seg_t load_seg,
	output logic      out_valid,
	input  logic      out_ready,
	output rubs_seg_t out_seg
);

	// valid flag: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_seg <= load_seg;
		end
	end

endmodule

@@ hw/rtl/read_unknown_base_splitter_unit.sv @@
// ---------------------------------------------------------------------------
// Unknown-base read splitter
// Splits a streamed read at unknown bases into k-mer usable segments.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one read character per word in s_tdata; s_tlast high marks
//   the end-of-read word, whose character is ignored.
//   Master stream: one segment per word, start and exclusive end offsets in
//   m_tdata; m_tlast is high for the remainder emitted at end of read.
//   Config: cfg_we writes cfg_data to register cfg_index (0 kmer_size,
//   1 tolerated_unknowns); write only while no word is in flight.
// Timing:
//   One word accepted per cycle while the receiver keeps up. A segment
//   appears on m_tvalid once the word that closes it has been accepted into
//   the input register and the tracker, working on that register, has
//   loaded the result register. Words that close nothing give no output word.
//   When the receiver stalls with a segment held, the tracker stops and
//   s_tready falls once the input register is full; nothing is dropped.
// Reset:
//   arst_n clears all read state and returns the registers to kmer_size 31
//   and tolerated_unknowns 0. Characters at offsets of MAX_LEN or more are
//   ignored until end of read.
// ---------------------------------------------------------------------------
module read_unknown_base_splitter_unit
	import rubs_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] symbol
	input  logic                 s_tlast,   // end_of_read
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [12:0] segment_start, [25:13] segment_end
	output logic                 m_tlast,   // final_segment
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic              valid_s1, advance, res_valid;
	rubs_item_t        in_item, item_s1;
	rubs_seg_t         res, out_seg;
	logic [KMER_W-1:0] kmer_size_q;
	logic [TOL_W-1:0]  tol_unk_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_size_q <= KMER_RESET;
			tol_unk_q   <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KMER_SIZE: kmer_size_q <= cfg_data[KMER_W-1:0];
				REG_TOL_UNK:   tol_unk_q   <= cfg_data[TOL_W-1:0];
				default:       ;
			endcase
		end
	end

	assign in_item.sym = s_tdata;
	assign in_item.eor = s_tlast;

	// held word moves on when the result register is free or draining
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	rubs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rubs_seg_tracker #(
		.MAX_LEN (MAX_LEN)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.kmer_size (kmer_size_q),
		.tol_unk   (tol_unk_q),
		.res_valid (res_valid),
		.res       (res)
	);

	rubs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_seg  (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_seg   (out_seg)
	);

	// output word packing
	assign m_tdata = {6'd0, out_seg.seg_end, out_seg.seg_start};
	assign m_tlast = out_seg.fin;

endmodule
